// File: design/bgc_pkg.sv
// bgc_pkg: shared types, codes and sizes for the button gesture classifier
// no dependencies; used by bgc_step and button_gesture_classifier_core
package bgc_pkg;

   localparam int COUNT_BITS = 12;
   localparam int CFG_BITS   = 12;
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(500);
   localparam logic [CFG_BITS-1:0] DC_WINDOW_RESET  = CFG_BITS'(500);

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_PRESS   = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE           = 2'd0,
      PH_FIRST_PRESSED  = 2'd1,
      PH_FIRST_RELEASED = 2'd2,
      PH_SECOND_PRESSED = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_NEXT     = 3'd1,
      ACT_PREV     = 3'd2,
      ACT_PAUSE    = 3'd3,
      ACT_CONTINUE = 3'd4,
      ACT_START    = 3'd5
   } action_type;

   typedef enum logic {
      REG_LONG_PRESS = 1'b0,
      REG_DC_WINDOW  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       started;
      logic       paused;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] phase_now;
   } rsp_type;

   // classifier state carried between items
   typedef struct packed {
      phase_type             phase;
      logic [COUNT_BITS-1:0] elapsed;
   } state_type;

endpackage

// File: design/button_gesture_classifier_core.sv
// button_gesture_classifier_core: top level, state, config and result registers
// depends on bgc_pkg and bgc_step
//
// usage:
//   req channel: one beat per millisecond tick, key press or key release,
//     with the player flags. csr channel: writes long_press_ms (index 0) and
//     double_click_window_ms (index 1); always ready, write only while idle.
//   rsp channel: exactly one beat per req beat, in order: the action taken
//     (none, next, previous, pause, continue, start) and the phase after it.
//   latency: the result appears in the cycle after the req beat is taken.
//   throughput: one item per cycle while rsp_ready stays high; the state update is one pass of
//     counter increment, compare and phase select feeding the state and
//     result registers.
//   reset: phase idle, counter zero, both thresholds 500, no result pending.
//   stall: while a result waits and rsp_ready is low, req_ready is low;
//     req_ready follows rsp_ready combinationally so no cycle is lost.
module button_gesture_classifier_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bgc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bgc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [bgc_pkg::CFG_BITS-1:0]     csr_data
);

   bgc_pkg::state_type             state_ff;
   bgc_pkg::state_type             state_in;
   bgc_pkg::action_type            action_in;
   logic [bgc_pkg::CFG_BITS-1:0]   long_press_ff;
   logic [bgc_pkg::CFG_BITS-1:0]   window_ff;
   logic                           rsp_valid_ff;
   bgc_pkg::rsp_type               rsp_data_ff;
   logic                           req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bgc_step u_step (
      .req                    (req_data),
      .cur                    (state_ff),
      .long_press_ms          (long_press_ff),
      .double_click_window_ms (window_ff),
      .nxt                    (state_in),
      .action                 (action_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= bgc_pkg::PH_IDLE;
         state_ff.elapsed <= '0;
         long_press_ff    <= bgc_pkg::LONG_PRESS_RESET;
         window_ff        <= bgc_pkg::DC_WINDOW_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (bgc_pkg::reg_index_type'(csr_index))
               bgc_pkg::REG_LONG_PRESS: long_press_ff <= csr_data;
               bgc_pkg::REG_DC_WINDOW:  window_ff     <= csr_data;
               default: ;
            endcase
         end
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff.action    <= action_in;
         rsp_data_ff.phase_now <= state_in.phase;
      end
   end

`ifndef ASSERT_OFF
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted item produced no result");

   a_next_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action == bgc_pkg::ACT_NEXT)
         |-> rsp_data.phase_now == bgc_pkg::PH_SECOND_PRESSED)
      else $error("next action without second press phase");

   a_gesture_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == bgc_pkg::ACT_PREV ||
                     rsp_data.action == bgc_pkg::ACT_PAUSE ||
                     rsp_data.action == bgc_pkg::ACT_CONTINUE ||
                     rsp_data.action == bgc_pkg::ACT_START))
         |-> rsp_data.phase_now == bgc_pkg::PH_IDLE)
      else $error("completed gesture did not return to idle");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_data.phase_now == state_ff.phase)
      else $error("reported phase differs from state register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && state_ff.phase == bgc_pkg::PH_IDLE))
      else $error("reset left a result or a phase");
`endif

endmodule

// File: design/bgc_step.sv
// bgc_step: next-state and action logic for one tick or key event
// depends on bgc_pkg
module bgc_step (
   input  bgc_pkg::req_type                 req,
   input  bgc_pkg::state_type               cur,
   input  logic [bgc_pkg::CFG_BITS-1:0]     long_press_ms,
   input  logic [bgc_pkg::CFG_BITS-1:0]     double_click_window_ms,
   output bgc_pkg::state_type               nxt,
   output bgc_pkg::action_type              action
);

   logic [bgc_pkg::COUNT_BITS-1:0] count_up;
   logic [bgc_pkg::CMP_BITS-1:0]   up_ext;
   logic [bgc_pkg::CMP_BITS-1:0]   cur_ext;
   logic [bgc_pkg::CMP_BITS-1:0]   long_ext;
   logic [bgc_pkg::CMP_BITS-1:0]   window_ext;
   bgc_pkg::action_type            single_click;

   // saturating tick counter
   assign count_up = (cur.elapsed == {bgc_pkg::COUNT_BITS{1'b1}}) ? cur.elapsed
                     : cur.elapsed + bgc_pkg::COUNT_BITS'(1);

   assign up_ext     = bgc_pkg::CMP_BITS'(count_up);
   assign cur_ext    = bgc_pkg::CMP_BITS'(cur.elapsed);
   assign long_ext   = bgc_pkg::CMP_BITS'(long_press_ms);
   assign window_ext = bgc_pkg::CMP_BITS'(double_click_window_ms);

   always_comb begin
      if (!req.started) begin
         single_click = bgc_pkg::ACT_START;
      end else if (req.paused) begin
         single_click = bgc_pkg::ACT_CONTINUE;
      end else begin
         single_click = bgc_pkg::ACT_PAUSE;
      end
   end

   always_comb begin
      nxt    = cur;
      action = bgc_pkg::ACT_NONE;
      case (bgc_pkg::mode_type'(req.mode))
         bgc_pkg::MODE_TICK: begin
            if (cur.phase == bgc_pkg::PH_FIRST_PRESSED) begin
               nxt.elapsed = count_up;
            end else if (cur.phase == bgc_pkg::PH_FIRST_RELEASED) begin
               nxt.elapsed = count_up;
               // window runs out: single click
               if (up_ext >= window_ext) begin
                  action    = single_click;
                  nxt.phase = bgc_pkg::PH_IDLE;
               end
            end
         end
         bgc_pkg::MODE_PRESS: begin
            if (cur.phase == bgc_pkg::PH_IDLE) begin
               nxt.elapsed = '0;
               nxt.phase   = bgc_pkg::PH_FIRST_PRESSED;
            end else if (cur.phase == bgc_pkg::PH_FIRST_RELEASED) begin
               action    = bgc_pkg::ACT_NEXT;
               nxt.phase = bgc_pkg::PH_SECOND_PRESSED;
            end
         end
         bgc_pkg::MODE_RELEASE: begin
            if (cur.phase == bgc_pkg::PH_FIRST_PRESSED) begin
               if (cur_ext > long_ext) begin
                  action    = bgc_pkg::ACT_PREV;
                  nxt.phase = bgc_pkg::PH_IDLE;
               end else begin
                  nxt.elapsed = '0;
                  nxt.phase   = bgc_pkg::PH_FIRST_RELEASED;
               end
            end else if (cur.phase == bgc_pkg::PH_SECOND_PRESSED) begin
               nxt.phase = bgc_pkg::PH_IDLE;
            end
         end
         default: begin
            nxt    = cur;
            action = bgc_pkg::ACT_NONE;
         end
      endcase
   end

endmodule

// File: tb/button_gesture_classifier_core_test.sv
// button_gesture_classifier_core_test: self-checking bench for the gesture classifier core
// holds a scoreboard class with its own gesture predictor; depends on bgc_pkg and the core
module button_gesture_classifier_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NEAR_CAP = 64;
   localparam int HOLD_OFF_CYCLES = 60;

   class gesture_scoreboard;
      logic [bgc_pkg::CFG_BITS-1:0]   long_press_limit;
      logic [bgc_pkg::CFG_BITS-1:0]   click_window;
      bgc_pkg::phase_type             phase;
      logic [bgc_pkg::COUNT_BITS-1:0] elapsed;
      bgc_pkg::rsp_type               pending_actions[$];
      int                             mismatches;

      function new();
         long_press_limit = bgc_pkg::LONG_PRESS_RESET;
         click_window     = bgc_pkg::DC_WINDOW_RESET;
         phase            = bgc_pkg::PH_IDLE;
         elapsed          = '0;
         mismatches       = 0;
      endfunction

      function void set_reg(bgc_pkg::reg_index_type idx, logic [bgc_pkg::CFG_BITS-1:0] value);
         if (idx == bgc_pkg::REG_LONG_PRESS)
            long_press_limit = value;
         else
            click_window = value;
      endfunction

      function void bump_elapsed();
         if (elapsed != {bgc_pkg::COUNT_BITS{1'b1}})
            elapsed = elapsed + bgc_pkg::COUNT_BITS'(1);
      endfunction

      function bgc_pkg::action_type single_click_action(logic started, logic paused);
         if (started)
            return paused ? bgc_pkg::ACT_CONTINUE : bgc_pkg::ACT_PAUSE;
         return bgc_pkg::ACT_START;
      endfunction

      function void note_event(bgc_pkg::req_type item);
         bgc_pkg::action_type act;
         bgc_pkg::rsp_type    want;
         act = bgc_pkg::ACT_NONE;
         case (bgc_pkg::mode_type'(item.mode))
            bgc_pkg::MODE_TICK: begin
               if (phase == bgc_pkg::PH_FIRST_PRESSED) begin
                  bump_elapsed();
               end else if (phase == bgc_pkg::PH_FIRST_RELEASED) begin
                  bump_elapsed();
                  if (elapsed >= click_window) begin
                     act   = single_click_action(item.started, item.paused);
                     phase = bgc_pkg::PH_IDLE;
                  end
               end
            end
            bgc_pkg::MODE_PRESS: begin
               if (phase == bgc_pkg::PH_IDLE) begin
                  elapsed = '0;
                  phase   = bgc_pkg::PH_FIRST_PRESSED;
               end else if (phase == bgc_pkg::PH_FIRST_RELEASED) begin
                  act   = bgc_pkg::ACT_NEXT;
                  phase = bgc_pkg::PH_SECOND_PRESSED;
               end
            end
            bgc_pkg::MODE_RELEASE: begin
               if (phase == bgc_pkg::PH_FIRST_PRESSED) begin
                  if (elapsed > long_press_limit) begin
                     act   = bgc_pkg::ACT_PREV;
                     phase = bgc_pkg::PH_IDLE;
                  end else begin
                     elapsed = '0;
                     phase   = bgc_pkg::PH_FIRST_RELEASED;
                  end
               end else if (phase == bgc_pkg::PH_SECOND_PRESSED) begin
                  phase = bgc_pkg::PH_IDLE;
               end
            end
            default: ;
         endcase
         want.action    = act;
         want.phase_now = phase;
         pending_actions.push_back(want);
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_result(bgc_pkg::rsp_type got);
         bgc_pkg::rsp_type want;
         if (pending_actions.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, action %0d phase %0d",
                                      got.action, got.phase_now));
            return;
         end
         want = pending_actions.pop_front();
         if (got.action !== want.action)
            report_mismatch($sformatf("action %0d, predicted %0d", got.action, want.action));
         if (got.phase_now !== want.phase_now)
            report_mismatch($sformatf("phase_now %0d, predicted %0d",
                                      got.phase_now, want.phase_now));
      endtask

      task finish_check();
         if (pending_actions.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_actions.size()));
      endtask
   endclass

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   bgc_pkg::req_type             req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   bgc_pkg::rsp_type             rsp_data;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic                         csr_index = 1'b0;
   logic [bgc_pkg::CFG_BITS-1:0] csr_data  = '0;

   gesture_scoreboard sb = new();

   int long_cfg   = int'(bgc_pkg::LONG_PRESS_RESET);
   int window_cfg = int'(bgc_pkg::DC_WINDOW_RESET);
   int gesture_items = 0;
   bit no_gaps = 1'b0;
   bit rsp_hold_request = 1'b0;
   int hold_left = 0;

   button_gesture_classifier_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = no_gaps || ($urandom_range(99) >= 26);
      end
   end

   // result is checked before the new beat is noted; its result is registered and shows in the following cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (req_valid && req_ready)
            sb.note_event(req_data);
      end
   end

   initial begin
      #2_000_000;
      $display("button_gesture_classifier_core regression: fail");
      $finish;
   end

   // entered at a falling edge; leaves valid high after the beat is taken
   task automatic offer(bgc_pkg::req_type item);
      while (!no_gaps && $urandom_range(99) < 26) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put(bgc_pkg::mode_type mode, bit started, bit paused);
      bgc_pkg::req_type item;
      item.mode    = mode;
      item.started = started;
      item.paused  = paused;
      offer(item);
   endtask

   task automatic send_event(bgc_pkg::mode_type mode);
      int roll;
      roll = $urandom_range(99);
      // occasional noise beat ahead of the real one
      if (roll < 4)
         put(bgc_pkg::MODE_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (roll == 4)
         put(bgc_pkg::mode_type'($urandom_range(3)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
      put(mode, 1'($urandom_range(1)), 1'($urandom_range(1)));
      gesture_items++;
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending_actions.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(bgc_pkg::reg_index_type idx, int value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value[bgc_pkg::CFG_BITS-1:0];
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.set_reg(idx, csr_data);
      @(negedge clock);
   endtask

   task automatic configure(int long_press, int window);
      wait_drained();
      write_reg(bgc_pkg::REG_LONG_PRESS, long_press);
      write_reg(bgc_pkg::REG_DC_WINDOW, window);
      csr_valid  = 1'b0;
      long_cfg   = long_press;
      window_cfg = window;
   endtask

   // lengths around a threshold when it is cheap to reach, short otherwise
   function automatic int pick_len(int limit);
      if (limit > NEAR_CAP)
         return $urandom_range(12);
      case ($urandom_range(4))
         0: return 0;
         1: return (limit > 0) ? limit - 1 : 0;
         2: return limit;
         3: return limit + 1;
         default: return $urandom_range(limit + 2);
      endcase
   endfunction

   task automatic play_gesture();
      repeat ($urandom_range(2)) send_event(bgc_pkg::MODE_TICK);
      if ($urandom_range(9) == 0)
         send_event(bgc_pkg::MODE_RELEASE);
      send_event(bgc_pkg::MODE_PRESS);
      repeat (pick_len(long_cfg)) send_event(bgc_pkg::MODE_TICK);
      if ($urandom_range(9) == 0)
         send_event(bgc_pkg::MODE_PRESS);
      send_event(bgc_pkg::MODE_RELEASE);
      if ($urandom_range(9) == 0)
         send_event(bgc_pkg::MODE_RELEASE);
      repeat (pick_len(window_cfg)) send_event(bgc_pkg::MODE_TICK);
      // second press: a double click inside the window, a fresh press after it
      if ($urandom_range(3) != 0) begin
         send_event(bgc_pkg::MODE_PRESS);
         if ($urandom_range(9) == 0)
            send_event(bgc_pkg::MODE_PRESS);
         repeat ($urandom_range(3)) send_event(bgc_pkg::MODE_TICK);
         send_event(bgc_pkg::MODE_RELEASE);
      end
   endtask

   task automatic run_gestures(int budget);
      int first;
      first = gesture_items;
      while (gesture_items - first < budget)
         play_gesture();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every action and the ignored cases
      configure(2, 1);
      put(bgc_pkg::MODE_RELEASE, 1'b0, 1'b0);
      put(bgc_pkg::MODE_TICK, 1'b1, 1'b1);
      put(bgc_pkg::MODE_UNUSED, 1'b1, 1'b0);
      put(bgc_pkg::MODE_PRESS, 1'b0, 1'b1);
      put(bgc_pkg::MODE_PRESS, 1'b1, 1'b0);
      repeat (3) put(bgc_pkg::MODE_TICK, 1'b0, 1'b0);
      put(bgc_pkg::MODE_RELEASE, 1'b1, 1'b1);
      put(bgc_pkg::MODE_PRESS, 1'b0, 1'b0);
      put(bgc_pkg::MODE_TICK, 1'b1, 1'b1);
      put(bgc_pkg::MODE_RELEASE, 1'b0, 1'b0);
      put(bgc_pkg::MODE_RELEASE, 1'b1, 1'b1);
      put(bgc_pkg::MODE_PRESS, 1'b0, 1'b0);
      put(bgc_pkg::MODE_PRESS, 1'b1, 1'b1);
      put(bgc_pkg::MODE_TICK, 1'b1, 1'b0);
      put(bgc_pkg::MODE_RELEASE, 1'b0, 1'b1);
      put(bgc_pkg::MODE_PRESS, 1'b0, 1'b0);
      put(bgc_pkg::MODE_RELEASE, 1'b0, 1'b0);
      put(bgc_pkg::MODE_TICK, 1'b1, 1'b0);
      put(bgc_pkg::MODE_PRESS, 1'b1, 1'b1);
      put(bgc_pkg::MODE_RELEASE, 1'b1, 1'b1);
      put(bgc_pkg::MODE_TICK, 1'b1, 1'b1);
      put(bgc_pkg::MODE_PRESS, 1'b0, 1'b1);
      put(bgc_pkg::MODE_RELEASE, 1'b1, 1'b0);
      put(bgc_pkg::MODE_TICK, 1'b0, 1'b1);

      // zero thresholds: any tick makes a long press, window closes at once
      configure(0, 0);
      run_gestures(150);

      no_gaps = 1'b1;
      configure(1, 1);
      run_gestures(250);
      no_gaps = 1'b0;

      // all-ones thresholds: hold never long, window not reached by the short tick runs
      configure(4095, 4095);
      run_gestures(150);

      configure(500, 500);
      run_gestures(200);
      configure(4095, 1);
      run_gestures(150);
      configure(1, 4095);
      run_gestures(150);

      for (int pass_idx = 0; pass_idx < 4; pass_idx++) begin
         configure($urandom_range(16), $urandom_range(16));
         if (pass_idx == 0)
            rsp_hold_request = 1'b1;
         if (pass_idx == 2) begin
            run_gestures(100);
            wait_drained();
            run_gestures(100);
         end else begin
            run_gestures(200);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      sb.finish_check();
      if (sb.mismatches == 0)
         $display("button_gesture_classifier_core regression: pass");
      else
         $display("button_gesture_classifier_core regression: fail");
      $finish;
   end

endmodule

// File: files.f
design/bgc_pkg.sv
design/bgc_step.sv
design/button_gesture_classifier_core.sv
tb/button_gesture_classifier_core_test.sv
